@@ hw/rtl/rtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, codes and constants of the reaction timer controller.
// ----------------------------------------------------------------------------
package rtc_pkg;

	// time counters
	localparam int TIME_BITS = 16;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// configuration registers
	localparam int CFG_W = 16;
	localparam int IDX_W = 3;
	localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	localparam logic [IDX_W-1:0] REG_MIN_WAIT = 3'd0;
	localparam logic [IDX_W-1:0] REG_SPAN     = 3'd1;
	localparam logic [IDX_W-1:0] REG_LIMIT    = 3'd2;
	localparam logic [IDX_W-1:0] REG_PAUSE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_SEED     = 3'd4;
	localparam logic [IDX_W-1:0] REG_TAPS     = 3'd5;

	localparam logic [CFG_W-1:0] RST_MIN_WAIT = 16'd1000;
	localparam logic [CFG_W-1:0] RST_SPAN     = 16'd4001;
	localparam logic [CFG_W-1:0] RST_LIMIT    = 16'd3000;
	localparam logic [CFG_W-1:0] RST_PAUSE    = 16'd2000;
	localparam logic [CFG_W-1:0] RST_SEED     = 16'hBEEF;
	localparam logic [CFG_W-1:0] RST_TAPS     = 16'hB400;

	// remainder unit
	localparam int DIV_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_WAIT  = 2'd1,
		PH_REACT = 2'd2,
		PH_PAUSE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_FALSE = 2'd1,
		EV_REACT = 2'd2,
		EV_SLOW  = 2'd3
	} event_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_sts_t;

endpackage

@@ hw/rtl/rtc_evt_if.sv @@
// ----------------------------------------------------------------------------
// rtc_evt_if
// Event channel: one item per millisecond tick or button edge.
// ----------------------------------------------------------------------------
interface rtc_evt_if;
	logic valid;
	logic ready;
	logic ms_tick;
	logic press;

	modport source (output valid, output ms_tick, output press, input ready);
	modport sink (input valid, input ms_tick, input press, output ready);
endinterface

@@ hw/rtl/rtc_res_if.sv @@
// ----------------------------------------------------------------------------
// rtc_res_if
// Result channel: lamp, marker, event code, reaction time and phase.
// ----------------------------------------------------------------------------
interface rtc_res_if;
	logic        valid;
	logic        ready;
	logic        lamp;
	logic        round_marker;
	logic [1:0]  event_res;
	logic [15:0] reaction_ms;
	logic [1:0]  phase_now;

	modport source (output valid, output lamp, output round_marker, output event_res,
		output reaction_ms, output phase_now, input ready);
	modport sink (input valid, input lamp, input round_marker, input event_res,
		input reaction_ms, input phase_now, output ready);
endinterface

@@ hw/rtl/rtc_rem.sv @@
// ----------------------------------------------------------------------------
// rtc_rem
// Restoring remainder unit, one dividend bit per cycle. A zero divisor
// returns the dividend unchanged.
// ----------------------------------------------------------------------------
module rtc_rem
	import rtc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output rem_sts_t         sts,
	output logic [DIV_W-1:0] rem
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W:0]       trial;

	assign trial = {rem_q, dvd_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= DIV_CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			// for a nonzero divisor the partial remainder stays below it, so it fits DIV_W bits
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= DIV_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = rem_q;

endmodule

@@ hw/rtl/reaction_timer_controller_core.sv @@
// ----------------------------------------------------------------------------
// reaction_timer_controller_core
// Reaction test rounds: random wait from an LFSR, lamp, reaction measurement,
// false start and timeout detection, pause between rounds.
// ----------------------------------------------------------------------------
// result: each item's result is registered in the output register when the item is accepted
// flow: a new item is accepted while the sequencer is idle and the result register
// is empty or being read; after a round-start item the next item waits until the
// delay remainder has run through the 16-step remainder unit
// reset: phase start, lfsr loaded with the seed reset value, counters cleared,
// configuration registers at their reset values, no result pending
module reaction_timer_controller_core
	import rtc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	rtc_evt_if.sink          evt,
	rtc_res_if.source        res,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DRAW = 2'b10
	} ctl_state_t;

	ctl_state_t           state_q;
	logic [CFG_W-1:0]     min_wait_q, span_q, limit_q, pause_q, seed_q, taps_q;
	phase_t               phase_q;
	logic [DIV_W-1:0]     lfsr_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TIME_BITS-1:0] delay_q;
	logic                 lamp_q;
	logic                 marker_q;

	logic                 res_valid_q;
	logic                 res_lamp_q, res_marker_q;
	event_t               res_event_q;
	logic [15:0]          res_react_q;
	phase_t               res_phase_q;

	logic                 accept;
	logic [DIV_W-1:0]     lfsr_next;
	logic [TIME_BITS-1:0] el_inc;
	logic [CMP_W-1:0]     el_cmp;
	rem_sts_t             rem_sts;
	logic [DIV_W-1:0]     rem_val;
	logic [CMP_W:0]       delay_sum;

	// next-state of one step
	phase_t               n_phase;
	logic [TIME_BITS-1:0] n_elapsed;
	logic                 n_lamp, n_marker;
	event_t               n_event;
	logic [15:0]          n_react;

	assign evt.ready = (state_q == S_IDLE) && (!res_valid_q || res.ready);
	assign accept    = evt.valid && evt.ready;

	assign lfsr_next = lfsr_q[0] ? ({1'b0, lfsr_q[DIV_W-1:1]} ^ taps_q)
		: {1'b0, lfsr_q[DIV_W-1:1]};

	assign el_inc = (evt.ms_tick && (elapsed_q != TIME_MAX)) ? elapsed_q + 1'b1 : elapsed_q;
	assign el_cmp = CMP_W'(el_inc);

	always_comb begin
		n_phase   = phase_q;
		n_elapsed = el_inc;
		n_lamp    = lamp_q;
		n_marker  = marker_q;
		n_event   = EV_NONE;
		n_react   = '0;
		case (phase_q)
			PH_START: begin
				n_lamp    = 1'b0;
				n_marker  = 1'b0;
				n_elapsed = '0;
				n_phase   = PH_WAIT;
			end
			PH_WAIT: begin
				if (el_inc >= delay_q) begin
					n_lamp    = 1'b1;
					n_marker  = 1'b1;
					n_elapsed = '0;
					n_phase   = PH_REACT;
				end else if (evt.press) begin
					n_event   = EV_FALSE;
					n_lamp    = 1'b0;
					n_elapsed = '0;
					n_phase   = PH_PAUSE;
				end
			end
			PH_REACT: begin
				if (evt.press) begin
					n_event   = EV_REACT;
					n_react   = 16'(el_inc);
					n_lamp    = 1'b0;
					n_elapsed = '0;
					n_phase   = PH_PAUSE;
				end else if (el_cmp > CMP_W'(limit_q)) begin
					n_event   = EV_SLOW;
					n_lamp    = 1'b0;
					n_elapsed = '0;
					n_phase   = PH_PAUSE;
				end
			end
			PH_PAUSE: begin
				if (el_cmp >= CMP_W'(pause_q)) begin
					n_elapsed = '0;
					n_phase   = PH_START;
				end
			end
			default: begin
				n_phase = PH_START;
			end
		endcase
	end

	rtc_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (phase_q == PH_START)),
		.dividend (lfsr_next),
		.divisor  (span_q),
		.sts      (rem_sts),
		.rem      (rem_val)
	);

	assign delay_sum = (CMP_W + 1)'(min_wait_q) + (CMP_W + 1)'(rem_val);

	// configuration registers and the lfsr
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_wait_q <= RST_MIN_WAIT;
			span_q     <= RST_SPAN;
			limit_q    <= RST_LIMIT;
			pause_q    <= RST_PAUSE;
			seed_q     <= RST_SEED;
			taps_q     <= RST_TAPS;
			lfsr_q     <= RST_SEED;
		end else begin
			if (accept && (phase_q == PH_START)) begin
				lfsr_q <= lfsr_next;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MIN_WAIT: min_wait_q <= cfg_wdata;
					REG_SPAN:     span_q     <= cfg_wdata;
					REG_LIMIT:    limit_q    <= cfg_wdata;
					REG_PAUSE:    pause_q    <= cfg_wdata;
					REG_SEED: begin
						seed_q <= cfg_wdata;
						lfsr_q <= cfg_wdata;
					end
					REG_TAPS:     taps_q     <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// round state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_START;
			elapsed_q <= '0;
			delay_q   <= '0;
			lamp_q    <= 1'b0;
			marker_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						phase_q   <= n_phase;
						elapsed_q <= n_elapsed;
						lamp_q    <= n_lamp;
						marker_q  <= n_marker;
						if (phase_q == PH_START) begin
							state_q <= S_DRAW;
						end
					end
				end
				S_DRAW: begin
					if (rem_sts.done) begin
						// saturate min wait plus remainder at the counter limit
						if (delay_sum > (CMP_W + 1)'(TIME_MAX)) begin
							delay_q <= TIME_MAX;
						end else begin
							delay_q <= TIME_BITS'(delay_sum);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_lamp_q   <= n_lamp;
			res_marker_q <= n_marker;
			res_event_q  <= n_event;
			res_react_q  <= n_react;
			res_phase_q  <= n_phase;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.lamp         = res_lamp_q;
	assign res.round_marker = res_marker_q;
	assign res.event_res    = res_event_q;
	assign res.reaction_ms  = res_react_q;
	assign res.phase_now    = res_phase_q;

	// seed register is kept for visibility of the configured value
	logic seed_nz;
	assign seed_nz = |seed_q;

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rem_sts.busy |-> !evt.ready)
		else $error("item accepted while remainder unit busy");

	a_lamp_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.lamp == (res.phase_now == PH_REACT)))
		else $error("lamp state disagrees with phase");

	a_event_pause: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.event_res != EV_NONE)) |-> (res.phase_now == PH_PAUSE))
		else $error("outcome reported outside pause entry");

	a_draw_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAW) && rem_sts.done |=> (state_q == S_IDLE) && !rem_sts.busy)
		else $error("sequencer did not return to idle after delay draw");

	a_seed_load: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && (cfg_index == REG_SEED) |=> (lfsr_q == seed_q) && (seed_nz == |lfsr_q))
		else $error("seed write did not load the lfsr");

endmodule

@@ verif/reaction_timer_controller_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reaction_timer_controller_core_tb
// Self-checking bench for the reaction timer core. A directed table walks the
// reset state, false start, reaction, timeout, zero span, zero seed, zero pause
// and saturated delays. Random rounds follow under several register settings.
// Every result is checked against its table entry or a local timer model, with
// random gaps and stalls on both channels and one long result stall.
// ----------------------------------------------------------------------------
module reaction_timer_controller_core_tb;
	import rtc_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 20;
	localparam int PHASE_ITEMS   = 120;
	localparam int RANDOM_PHASES = 8;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic        lamp;
		logic        marker;
		event_t      ev;
		logic [15:0] react_ms;
		phase_t      ph;
	} outcome_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] val;
		logic             tick;
		logic             press;
		logic             typed;
		outcome_t         want;
	} row_t;

	localparam outcome_t ANY = '{1'b0, 1'b0, EV_NONE, 16'd0, PH_START};

	localparam int PLAN_ROWS = 36;
	localparam row_t PLAN [PLAN_ROWS] = '{
		// kind, register, value, tick, press, typed, expected result
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, EV_NONE, 16'd0, PH_WAIT}},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, EV_FALSE, 16'd0, PH_PAUSE}},
		'{ROW_CFG, REG_PAUSE, 16'd0, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, EV_NONE, 16'd0, PH_START}},
		'{ROW_CFG, REG_MIN_WAIT, 16'd1, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_CFG, REG_SPAN, 16'd1, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, EV_NONE, 16'd0, PH_WAIT}},
		// lamp lights on this item, its press is dropped
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, EV_NONE, 16'd0, PH_REACT}},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b1, EV_REACT, 16'd1, PH_PAUSE}},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, EV_NONE, 16'd0, PH_START}},
		'{ROW_CFG, REG_LIMIT, 16'd0, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, EV_NONE, 16'd0, PH_WAIT}},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, EV_NONE, 16'd0, PH_REACT}},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b1, EV_SLOW, 16'd0, PH_PAUSE}},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, EV_NONE, 16'd0, PH_START}},
		// zero seed and zero span: the wait is exactly min_wait
		'{ROW_CFG, REG_SEED, 16'd0, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_CFG, REG_MIN_WAIT, 16'd3, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_CFG, REG_SPAN, 16'd0, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, EV_NONE, 16'd0, PH_WAIT}},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b0, 1'b0, ANY},
		'{ROW_CFG, REG_LIMIT, 16'd65534, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b1, EV_REACT, 16'd0, PH_PAUSE}},
		'{ROW_CFG, REG_PAUSE, 16'd2, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b1, 1'b0, ANY},
		// all-ones registers: the drawn delay saturates
		'{ROW_CFG, REG_TAPS, 16'hFFFF, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_CFG, REG_SEED, 16'hFFFF, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_CFG, REG_SPAN, 16'hFFFF, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_CFG, REG_MIN_WAIT, 16'hFFFF, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b1, 1'b0, ANY},
		'{ROW_CFG, REG_PAUSE, 16'd1, 1'b0, 1'b0, 1'b0, ANY},
		'{ROW_ITEM, REG_MIN_WAIT, 16'd0, 1'b1, 1'b0, 1'b0, ANY}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	rtc_evt_if evt_ch ();
	rtc_res_if res_ch ();

	reaction_timer_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.res       (res_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// local copy of the timer state and its registers
	phase_t      m_phase;
	logic [15:0] m_lfsr;
	logic [15:0] m_elapsed;
	logic [15:0] m_delay;
	logic        m_lamp;
	logic        m_marker;
	logic [15:0] c_min_wait;
	logic [15:0] c_span;
	logic [15:0] c_limit;
	logic [15:0] c_pause;
	logic [15:0] c_taps;

	outcome_t pending_results [$];
	int       mismatches;
	int       results_seen;
	int       quiet_cycles;
	bit       tx_idle;
	bit       rx_idle;
	bit       hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == TIME_MAX) ? v : v + 16'd1;
	endfunction

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic string describe(input outcome_t o);
		return $sformatf("lamp=%0b marker=%0b event=%0d reaction=%0d phase=%0d",
			o.lamp, o.marker, o.ev, o.react_ms, o.ph);
	endfunction

	task automatic close_round();
		m_lamp = 1'b0;
		m_elapsed = 16'd0;
		m_phase = PH_PAUSE;
	endtask

	task automatic advance_timer(input logic t, input logic p, output outcome_t r);
		logic [15:0] nxt;
		logic [15:0] extra;
		logic [16:0] sum;
		r = ANY;
		case (m_phase)
			PH_START: begin
				m_lamp = 1'b0;
				m_marker = 1'b0;
				nxt = {1'b0, m_lfsr[15:1]} ^ (m_lfsr[0] ? c_taps : 16'd0);
				m_lfsr = nxt;
				extra = (c_span == 16'd0) ? nxt : nxt % c_span;
				sum = {1'b0, c_min_wait} + {1'b0, extra};
				m_delay = sum[16] ? TIME_MAX : sum[15:0];
				m_elapsed = 16'd0;
				m_phase = PH_WAIT;
			end
			PH_WAIT: begin
				if (t) m_elapsed = bump(m_elapsed);
				if (m_elapsed >= m_delay) begin
					m_lamp = 1'b1;
					m_marker = 1'b1;
					m_elapsed = 16'd0;
					m_phase = PH_REACT;
				end else if (p) begin
					r.ev = EV_FALSE;
					close_round();
				end
			end
			PH_REACT: begin
				if (t) m_elapsed = bump(m_elapsed);
				if (p) begin
					r.ev = EV_REACT;
					r.react_ms = m_elapsed;
					close_round();
				end else if (m_elapsed > c_limit) begin
					r.ev = EV_SLOW;
					close_round();
				end
			end
			default: begin
				if (t) m_elapsed = bump(m_elapsed);
				if (m_elapsed >= c_pause) begin
					m_elapsed = 16'd0;
					m_phase = PH_START;
				end
			end
		endcase
		r.lamp = m_lamp;
		r.marker = m_marker;
		r.ph = m_phase;
	endtask

	task automatic send_item(input logic t, input logic p, input logic typed,
		input outcome_t want);
		outcome_t predicted;
		int gap;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.ms_tick <= t;
		evt_ch.press <= p;
		do @(posedge clk); while (evt_ch.ready !== 1'b1);
		advance_timer(t, p, predicted);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// stop offering items, wait for every result and for a delay draw to finish
	task automatic quiesce();
		evt_ch.valid <= 1'b0;
		while (pending_results.size() != 0 || evt_ch.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MIN_WAIT: c_min_wait = val;
			REG_SPAN:     c_span = val;
			REG_LIMIT:    c_limit = val;
			REG_PAUSE:    c_pause = val;
			REG_SEED:     m_lfsr = val;
			REG_TAPS:     c_taps = val;
			default: ;
		endcase
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
	endtask

	initial begin : result_sink
		outcome_t got;
		outcome_t want;
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				gap = HOLD_CYCLES;
				hold_off = 1'b0;
			end else begin
				gap = rx_idle ? $urandom_range(0, 10) : 0;
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			got.lamp = res_ch.lamp;
			got.marker = res_ch.round_marker;
			got.ev = event_t'(res_ch.event_res);
			got.react_ms = res_ch.reaction_ms;
			got.ph = phase_t'(res_ch.phase_now);
			results_seen++;
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("result %0d with nothing expected: %s",
					results_seen, describe(got)));
			end else begin
				want = pending_results.pop_front();
				if (got.lamp !== want.lamp || got.marker !== want.marker ||
					got.ev !== want.ev || got.react_ms !== want.react_ms ||
					got.ph !== want.ph) begin
					note_mismatch($sformatf("result %0d expected %s, got %s",
						results_seen, describe(want), describe(got)));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int k;
		int ph;
		logic t;
		logic p;
		logic [15:0] span_pick;

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_MIN_WAIT;
		cfg_wdata <= '0;
		evt_ch.valid <= 1'b0;
		evt_ch.ms_tick <= 1'b0;
		evt_ch.press <= 1'b0;
		res_ch.ready <= 1'b0;
		mismatches = 0;
		results_seen = 0;
		quiet_cycles = 0;
		hold_off = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		m_phase = PH_START;
		m_lfsr = RST_SEED;
		m_elapsed = 16'd0;
		m_delay = 16'd0;
		m_lamp = 1'b0;
		m_marker = 1'b0;
		c_min_wait = RST_MIN_WAIT;
		c_span = RST_SPAN;
		c_limit = RST_LIMIT;
		c_pause = RST_PAUSE;
		c_taps = RST_TAPS;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < PLAN_ROWS; k++) begin
			if (PLAN[k].kind == ROW_CFG) begin
				quiesce();
				write_reg(PLAN[k].idx, PLAN[k].val);
			end else begin
				send_item(PLAN[k].tick, PLAN[k].press, PLAN[k].typed, PLAN[k].want);
			end
		end

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			quiesce();
			tx_idle = !(ph == 1 || ph == 2 || ph == 5);
			rx_idle = !(ph == 3 || ph == 5);
			case ($urandom_range(0, 7))
				0: span_pick = 16'd0;
				1: span_pick = 16'hFFFF;
				2: span_pick = 16'd1;
				default: span_pick = 16'($urandom_range(2, 16));
			endcase
			write_reg(REG_MIN_WAIT, (ph == 0) ? 16'd1 : 16'($urandom_range(1, 12)));
			write_reg(REG_SPAN, span_pick);
			write_reg(REG_LIMIT, 16'($urandom_range(0, 20)));
			write_reg(REG_PAUSE, 16'($urandom_range(0, 6)));
			write_reg(REG_SEED, chance(15) ? 16'd0 : 16'($urandom_range(1, 65535)));
			write_reg(REG_TAPS, 16'($urandom_range(0, 65535)));
			// block fills up while results are held back
			if (ph == 2) hold_off = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				case (m_phase)
					PH_WAIT: begin
						t = chance(75);
						p = chance(3);
					end
					PH_REACT: begin
						t = chance(70);
						p = chance(20);
					end
					default: begin
						t = chance(50);
						p = chance(30);
					end
				endcase
				send_item(t, p, 1'b0, ANY);
			end
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		end
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
